// ===== hdl/fso_pkg.sv =====
package fso_pkg;

    // Field widths fixed by the interface.
    localparam int ACT_W   = 3;
    localparam int FIDX_W  = 4;
    localparam int TS_W    = 64;
    localparam int FC_W    = 5;
    localparam int UCNT_W  = 5;

    // Frame count after reset.
    localparam logic [FC_W-1:0] FC_RESET = 5'd16;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_SET_USED    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET_TIME    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FIND_FIRST  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIND_SECOND = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ        = 3'd4;

    // One entry of the slot memory.
    typedef struct packed {
        logic            used;
        logic [TS_W-1:0] stamp;
    } slot_t;

    // Control from the sequencer to the search datapath.
    typedef struct packed {
        logic            clr_search;
        logic            clr_count;
        logic            sample;
        logic            count_en;
        logic            flag;
        logic [TS_W-1:0] lower;
    } srch_ctrl_t;

endpackage

// ===== hdl/fso_slot_mem.sv =====
module fso_slot_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  fso_pkg::slot_t    wr_slot,
    output fso_pkg::slot_t    rd_slot
);
    import fso_pkg::*;

    slot_t              mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic               rd_vld_reg;
    slot_t              rd_q_reg;

    // Entry valid bits; an entry never written reads as the reset value of zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Storage array with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_slot;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign rd_slot = rd_vld_reg ? rd_q_reg : '0;

endmodule

// ===== hdl/fso_search.sv =====
module fso_search #(
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fso_pkg::srch_ctrl_t     ctrl,
    input  logic [IDX_W-1:0]        sample_idx,
    input  fso_pkg::slot_t          rd_slot,
    output logic [fso_pkg::TS_W-1:0] best,
    output logic [IDX_W-1:0]        where_idx,
    output logic                    hit,
    output logic [CNT_W-1:0]        used_cnt
);
    import fso_pkg::*;

    logic [TS_W-1:0]  best_reg;
    logic [IDX_W-1:0] where_reg;
    logic             hit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             take;

    // A candidate wins only on a strictly smaller stamp, so ties keep the lower index.
    assign take = ctrl.sample && (rd_slot.used == ctrl.flag)
                  && (rd_slot.stamp >= ctrl.lower) && (rd_slot.stamp < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg  <= '1;
            where_reg <= '0;
            hit_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (ctrl.clr_search)
            begin
                best_reg  <= '1;
                where_reg <= '0;
                hit_reg   <= 1'b0;
            end
            else if (take)
            begin
                best_reg  <= rd_slot.stamp;
                where_reg <= sample_idx;
                hit_reg   <= 1'b1;
            end

            // Used count accumulates over the first pass only.
            if (ctrl.clr_count)
            begin
                cnt_reg <= '0;
            end
            else if (ctrl.sample && ctrl.count_en && rd_slot.used)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    assign best      = best_reg;
    assign where_idx = where_reg;
    assign hit       = hit_reg;
    assign used_cnt  = cnt_reg;

endmodule

// ===== hdl/frame_slot_oldest_finder.sv =====
// Frame slot table with oldest-slot search.
// Input channel: in_valid/in_ready carry one beat of action, frame_index,
// used_flag, timestamp and min_time. Output channel: out_valid/out_ready carry
// one result beat per input beat with found, result_index, slot_used,
// slot_timestamp and used_count.
// Every beat is handled by one sequencer around a single slot memory with one
// read and one write port: a read-modify-write of the addressed slot, then a
// scan that reads one slot per cycle. A second-earliest search scans again
// if the first scan found a used slot. One beat is worked on at a time; a
// new beat is accepted in the cycle after the previous result is loaded
// into the output register, even while the receiver stalls it. The result
// register holds its beat until out_ready; a further finished result waits.
// Reset clears the whole table, sets frame_count to 16 and empties the output.
// cfg_we writes frame_count, only while the block is idle: a rule for the
// user, which the block itself does not enforce.
module frame_slot_oldest_finder #(
    parameter int MAX_FRAMES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fso_pkg::FC_W-1:0]    cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [fso_pkg::ACT_W-1:0]   action,
    input  logic [fso_pkg::FIDX_W-1:0]  frame_index,
    input  logic                        used_flag,
    input  logic [fso_pkg::TS_W-1:0]    timestamp,
    input  logic [fso_pkg::TS_W-1:0]    min_time,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [fso_pkg::FIDX_W-1:0]  result_index,
    output logic                        slot_used,
    output logic [fso_pkg::TS_W-1:0]    slot_timestamp,
    output logic [fso_pkg::UCNT_W-1:0]  used_count
);
    import fso_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int EXT_W = 9;
    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_FRAMES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADDR = 3'd1;
    localparam logic [2:0] ST_MOD  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [FC_W-1:0]   fc_reg;
    logic [ACT_W-1:0]  act_reg;
    logic [FIDX_W-1:0] idx_reg;
    logic              flag_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [TS_W-1:0]   min_reg;
    logic              pass_reg, pass_next;
    logic [TS_W-1:0]   lower_reg, lower_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              rused_reg, rused_next;
    logic [TS_W-1:0]   rtime_reg, rtime_next;

    logic              out_valid_reg, out_valid_next;
    logic              found_reg;
    logic [FIDX_W-1:0] rindex_reg;
    logic              oused_reg;
    logic [TS_W-1:0]   otime_reg;
    logic [UCNT_W-1:0] ocnt_reg;

    logic [EXT_W-1:0]  fc_ext, n_full;
    logic [CNT_W-1:0]  active_n;
    logic              idx_ok;
    logic [IDX_W-1:0]  slot_addr;

    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic              mem_wr_en;
    slot_t             mem_wr_slot;
    slot_t             rd_slot;

    srch_ctrl_t        ctrl;
    logic [TS_W-1:0]   srch_best;
    logic [IDX_W-1:0]  srch_where;
    logic              srch_hit;
    logic [CNT_W-1:0]  srch_cnt;

    logic              pass_done;
    logic              found_w;
    logic              load_out;

    // Active slot count, with a frame count above capacity acting as capacity.
    assign fc_ext    = EXT_W'(fc_reg);
    assign n_full    = (fc_ext > MAX_EXT) ? MAX_EXT : fc_ext;
    assign active_n  = CNT_W'(n_full);
    assign idx_ok    = (EXT_W'(idx_reg) < n_full);
    assign slot_addr = IDX_W'(idx_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign pass_done = (issue_reg >= active_n) && !pend_reg;
    assign found_w   = srch_hit && ((act_reg == ACT_FIND_FIRST)
                                    || ((act_reg == ACT_FIND_SECOND) && pass_reg));
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    fso_slot_mem #(
        .DEPTH (MAX_FRAMES),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .wr_en   (mem_wr_en),
        .wr_addr (slot_addr),
        .wr_slot (mem_wr_slot),
        .rd_slot (rd_slot)
    );

    fso_search #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample_idx (pend_idx_reg),
        .rd_slot    (rd_slot),
        .best       (srch_best),
        .where_idx  (srch_where),
        .hit        (srch_hit),
        .used_cnt   (srch_cnt)
    );

    // Sequencer: slot read-modify-write, then one or two scans of the table.
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        lower_next     = lower_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        rused_next     = rused_reg;
        rtime_next     = rtime_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = slot_addr;
        mem_wr_en      = 1'b0;
        mem_wr_slot    = rd_slot;
        ctrl           = '0;
        ctrl.count_en  = !pass_reg;
        if (act_reg == ACT_FIND_FIRST)
        begin
            ctrl.flag  = flag_reg;
            ctrl.lower = min_reg;
        end
        else
        begin
            ctrl.flag  = 1'b1;
            ctrl.lower = lower_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                // Merge the new field into the slot read back and write it for an in-range index.
                if (act_reg == ACT_SET_USED)
                begin
                    mem_wr_en        = idx_ok;
                    mem_wr_slot.used = flag_reg;
                end
                else if (act_reg == ACT_SET_TIME)
                begin
                    mem_wr_en         = idx_ok;
                    mem_wr_slot.stamp = ts_reg;
                end
                if ((act_reg == ACT_READ) && idx_ok)
                begin
                    rused_next = rd_slot.used;
                    rtime_next = rd_slot.stamp;
                end
                else
                begin
                    rused_next = 1'b0;
                    rtime_next = '0;
                end
                ctrl.clr_search = 1'b1;
                ctrl.clr_count  = 1'b1;
                pass_next       = 1'b0;
                lower_next      = '0;
                issue_next      = '0;
                pend_next       = 1'b0;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Issue one slot read per cycle; its data is sampled in the cycle after.
                if (issue_reg < active_n)
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = IDX_W'(issue_reg);
                    pend_next     = 1'b1;
                    pend_idx_next = IDX_W'(issue_reg);
                    issue_next    = issue_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                ctrl.sample = pend_reg;
                if (pass_done)
                begin
                    if ((act_reg == ACT_FIND_SECOND) && !pass_reg && srch_hit)
                    begin
                        // Second pass looks strictly past the earliest stamp.
                        pass_next       = 1'b1;
                        lower_next      = srch_best + TS_W'(1);
                        issue_next      = '0;
                        ctrl.clr_search = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid clears when the receiver takes the beat and none replaces it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fc_reg        <= FC_RESET;
            pass_reg      <= 1'b0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                fc_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg  <= action;
            idx_reg  <= frame_index;
            flag_reg <= used_flag;
            ts_reg   <= timestamp;
            min_reg  <= min_time;
        end
        lower_reg    <= lower_next;
        pend_idx_reg <= pend_idx_next;
        rused_reg    <= rused_next;
        rtime_reg    <= rtime_next;
        if (load_out)
        begin
            found_reg  <= found_w;
            rindex_reg <= found_w ? FIDX_W'(srch_where) : '0;
            oused_reg  <= rused_reg;
            otime_reg  <= rtime_reg;
            ocnt_reg   <= UCNT_W'(srch_cnt);
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign result_index   = rindex_reg;
    assign slot_used      = oused_reg;
    assign slot_timestamp = otime_reg;
    assign used_count     = ocnt_reg;

    // An accepted beat always starts with the slot address phase.
    a_accept_to_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_ADDR))
        else $error("accepted beat did not start the slot access");

    // Sampled scan data must come from a read issued during the scan.
    a_pend_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_SCAN))
        else $error("scan sample without a scan read");

    // Only a second-earliest search runs a second pass.
    a_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && pass_reg) |-> (act_reg == ACT_FIND_SECOND))
        else $error("second pass for a single-pass action");

    // The used count never exceeds the number of active slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (srch_cnt <= active_n))
        else $error("used count above active slot count");

    // The table is written only in the modify step.
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> ($past(state_reg) == ST_ADDR))
        else $error("slot write outside read-modify-write");

endmodule

// ===== tb/tb_frame_slot_oldest_finder.sv =====
`timescale 1ns / 100ps

module tb_frame_slot_oldest_finder;
    import fso_pkg::*;

    localparam int NUM_SLOTS = 16;
    localparam int QUIET_LIMIT = 3000;
    localparam int SHOW_LIMIT = 10;
    localparam int NUM_PHASES = 8;
    localparam logic [TS_W-1:0] STAMP_MAX = '1;

    // Action codes that the block treats as no-ops.
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    // One input beat and one result beat.
    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [FIDX_W-1:0] idx;
        logic              flag;
        logic [TS_W-1:0]   stamp;
        logic [TS_W-1:0]   lower;
    } slot_cmd_t;

    typedef struct packed {
        logic              found;
        logic [FIDX_W-1:0] index;
        logic              used;
        logic [TS_W-1:0]   stamp;
        logic [UCNT_W-1:0] count;
    } slot_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [FC_W-1:0]     cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [ACT_W-1:0]    action = '0;
    logic [FIDX_W-1:0]   frame_index = '0;
    logic                used_flag = 1'b0;
    logic [TS_W-1:0]     timestamp = '0;
    logic [TS_W-1:0]     min_time = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                found;
    logic [FIDX_W-1:0]   result_index;
    logic                slot_used;
    logic [TS_W-1:0]     slot_timestamp;
    logic [UCNT_W-1:0]   used_count;

    // Mirror of the slot table and the frame count register.
    logic                mirror_used [NUM_SLOTS] = '{default: 1'b0};
    logic [TS_W-1:0]     mirror_stamp [NUM_SLOTS] = '{default: '0};
    logic [FC_W-1:0]     mirror_frames = FC_RESET;

    slot_cmd_t           cmd_backlog [$];
    slot_report_t        want_reports [$];
    int                  cmds_issued = 0;
    int                  cmds_accepted = 0;
    int                  fault_count = 0;
    int                  quiet_cycles = 0;
    logic                in_beat_taken = 1'b0;
    int                  send_gap = 0;
    logic                send_burst = 1'b0;
    int                  hold_left = 0;
    logic                recv_burst = 1'b0;
    logic [TS_W-1:0]     stamp_base = '0;
    logic [FC_W-1:0]     phase_frames [NUM_PHASES] = '{5'd0, 5'd1, 5'd9, 5'd31,
                                                       5'd16, 5'd17, 5'd4, 5'd16};
    int                  phase_items [NUM_PHASES] = '{60, 150, 300, 300, 400, 200, 165, 300};

    frame_slot_oldest_finder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .frame_index    (frame_index),
        .used_flag      (used_flag),
        .timestamp      (timestamp),
        .min_time       (min_time),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .result_index   (result_index),
        .slot_used      (slot_used),
        .slot_timestamp (slot_timestamp),
        .used_count     (used_count)
    );

    // Free-running 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Slots visible under the current frame count, capped at the table size.
    function automatic int live_slots();
        return (mirror_frames > NUM_SLOTS) ? NUM_SLOTS : int'(mirror_frames);
    endfunction

    // Scan upward for the lowest stamp at or above lower among slots with a
    // matching used flag. The strict compare keeps the lowest index on a tie
    // and never picks an all-ones stamp.
    function automatic logic oldest_slot(input logic flag, input logic [TS_W-1:0] lower,
                                         output logic [FIDX_W-1:0] slot);
        logic [TS_W-1:0] best;
        logic            hit;
        best = STAMP_MAX;
        hit = 1'b0;
        slot = '0;
        for (int i = 0; i < live_slots(); i++)
        begin
            if (mirror_used[i] == flag && mirror_stamp[i] >= lower && mirror_stamp[i] < best)
            begin
                best = mirror_stamp[i];
                slot = FIDX_W'(i);
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Apply one beat to the mirror and return the result it should produce.
    function automatic slot_report_t apply_slot_action(input slot_cmd_t cmd);
        slot_report_t      rep;
        logic [FIDX_W-1:0] first;
        logic [FIDX_W-1:0] second;
        logic              in_range;
        rep = '0;
        in_range = int'(cmd.idx) < live_slots();
        case (cmd.act)
            ACT_SET_USED:
                if (in_range)
                    mirror_used[cmd.idx] = cmd.flag;
            ACT_SET_TIME:
                if (in_range)
                    mirror_stamp[cmd.idx] = cmd.stamp;
            ACT_FIND_FIRST:
            begin
                rep.found = oldest_slot(cmd.flag, cmd.lower, first);
                rep.index = first;
            end
            ACT_FIND_SECOND:
                // Second search starts just past the earliest used stamp, so
                // slots tied with the earliest are skipped.
                if (oldest_slot(1'b1, '0, first))
                begin
                    rep.found = oldest_slot(1'b1, mirror_stamp[first] + TS_W'(1), second);
                    rep.index = second;
                end
            ACT_READ:
                if (in_range)
                begin
                    rep.used = mirror_used[cmd.idx];
                    rep.stamp = mirror_stamp[cmd.idx];
                end
            default: ;
        endcase
        for (int i = 0; i < live_slots(); i++)
            rep.count += UCNT_W'(mirror_used[i]);
        return rep;
    endfunction

    // Gap or stall length: mostly short, a few long, none in a burst.
    function automatic int gap_len(input logic burst);
        int roll;
        if (burst)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Stamps that favor ties, extremes and values clustered near a base.
    function automatic logic [TS_W-1:0] pick_stamp();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return TS_W'($urandom_range(0, 7));
        if (roll < 30)
            return STAMP_MAX;
        if (roll < 35)
            return STAMP_MAX - TS_W'(1);
        if (roll < 55)
            return stamp_base + TS_W'($urandom_range(0, 15));
        return {$urandom, $urandom};
    endfunction

    task automatic push_cmd(input logic [ACT_W-1:0] act, input logic [FIDX_W-1:0] idx,
                            input logic flag, input logic [TS_W-1:0] stamp,
                            input logic [TS_W-1:0] lower);
        cmd_backlog.push_back(slot_cmd_t'{act, idx, flag, stamp, lower});
        cmds_issued++;
    endtask

    // Hold the sender until every beat has been accepted and answered.
    task automatic drain();
        do
            @(negedge clk);
        while (cmds_accepted != cmds_issued || want_reports.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Frame count writes happen only with the block idle.
    task automatic write_frames(input logic [FC_W-1:0] frames);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = frames;
        mirror_frames = frames;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Input driver: launch a beat from the backlog after a random gap.
    always @(negedge clk)
    begin : driver
        slot_cmd_t next;
        logic      drive_valid;
        if (rst_n && (!in_valid || in_beat_taken))
        begin
            drive_valid = 1'b0;
            if (send_gap != 0)
                send_gap--;
            else if (cmd_backlog.size() != 0)
            begin
                next = cmd_backlog.pop_front();
                action <= next.act;
                frame_index <= next.idx;
                used_flag <= next.flag;
                timestamp <= next.stamp;
                min_time <= next.lower;
                drive_valid = 1'b1;
                send_gap = gap_len(send_burst);
                if ($urandom_range(0, 63) == 0)
                    send_burst = !send_burst;
            end
            in_valid <= drive_valid;
        end
    end

    // Result receiver: random stalls on out_ready.
    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    hold_left = gap_len(recv_burst);
                if ($urandom_range(0, 99) == 0)
                    recv_burst = !recv_burst;
            end
        end
    end

    // Monitor: predict on each accepted input beat, check each result beat.
    always @(posedge clk)
    begin : monitor
        slot_report_t got;
        slot_report_t want;
        in_beat_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            want_reports.push_back(apply_slot_action(
                slot_cmd_t'{action, frame_index, used_flag, timestamp, min_time}));
            cmds_accepted++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = slot_report_t'{found, result_index, slot_used, slot_timestamp, used_count};
            if (want_reports.size() == 0)
            begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT)
                    $display("%0t: result beat with nothing expected: found=%0b idx=%0d",
                             $realtime, got.found, got.index);
            end
            else
            begin
                want = want_reports.pop_front();
                if (got.found !== want.found || got.index !== want.index ||
                    got.used !== want.used || got.stamp !== want.stamp ||
                    got.count !== want.count)
                begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                    begin
                        $write("%0t: mismatch exp found=%0b idx=%0d used=%0b ts=%h cnt=%0d",
                               $realtime, want.found, want.index, want.used, want.stamp,
                               want.count);
                        $display(" got found=%0b idx=%0d used=%0b ts=%h cnt=%0d",
                                 got.found, got.index, got.used, got.stamp, got.count);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("frame_slot_oldest_finder verification failed");
                $finish;
            end
        end
    end

    // Stimulus: directed beats at the reset frame count, then random phases
    // under several frame counts, then the final check.
    initial
    begin : stimulus
        logic [ACT_W-1:0]  act;
        logic [FIDX_W-1:0] idx;
        logic [TS_W-1:0]   lower;
        int                roll;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_frames(FC_RESET);
        // Empty table: slot 0 wins a free-slot search, no used slots exist.
        push_cmd(ACT_READ, 4'd0, 1'b0, '0, '0);
        push_cmd(ACT_FIND_FIRST, 4'd0, 1'b0, '0, '0);
        push_cmd(ACT_FIND_SECOND, 4'd0, 1'b0, '0, '0);
        // Three used slots: one at all ones, two tied.
        push_cmd(ACT_SET_USED, 4'd0, 1'b1, '0, '0);
        push_cmd(ACT_SET_USED, 4'd5, 1'b1, '0, '0);
        push_cmd(ACT_SET_USED, 4'd15, 1'b1, '0, '0);
        push_cmd(ACT_SET_TIME, 4'd0, 1'b0, STAMP_MAX, '0);
        push_cmd(ACT_SET_TIME, 4'd5, 1'b0, 64'd100, '0);
        push_cmd(ACT_SET_TIME, 4'd15, 1'b0, 64'd100, '0);
        push_cmd(ACT_SET_TIME, 4'd3, 1'b0, 64'd100, '0);
        push_cmd(ACT_FIND_FIRST, 4'd0, 1'b1, '0, '0);
        // Tie with the earliest is skipped and all ones is never chosen.
        push_cmd(ACT_FIND_SECOND, 4'd0, 1'b0, '0, '0);
        push_cmd(ACT_SET_TIME, 4'd15, 1'b0, 64'd101, '0);
        push_cmd(ACT_FIND_SECOND, 4'd0, 1'b0, '0, '0);
        push_cmd(ACT_FIND_FIRST, 4'd0, 1'b1, '0, STAMP_MAX);
        push_cmd(ACT_FIND_FIRST, 4'd0, 1'b0, '0, 64'd1);
        push_cmd(ACT_FIND_FIRST, 4'd0, 1'b1, '0, 64'd101);
        push_cmd(ACT_READ, 4'd0, 1'b0, '0, '0);
        push_cmd(ACT_READ, 4'd15, 1'b1, STAMP_MAX, STAMP_MAX);
        push_cmd(ACT_SET_USED, 4'd7, 1'b1, '0, '0);
        push_cmd(ACT_SET_TIME, 4'd7, 1'b0, STAMP_MAX - 64'd1, '0);
        push_cmd(ACT_FIND_FIRST, 4'd0, 1'b1, '0, STAMP_MAX - 64'd1);
        push_cmd(ACT_SET_USED, 4'd5, 1'b0, '0, '0);
        push_cmd(ACT_SPARE_LO, 4'($urandom), 1'($urandom), {$urandom, $urandom},
                 {$urandom, $urandom});
        push_cmd(ACT_SPARE_HI, 4'd15, 1'b1, STAMP_MAX, STAMP_MAX);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_frames(phase_frames[p]);
            stamp_base = {$urandom, $urandom};
            for (int n = 0; n < phase_items[p]; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 20)
                    act = ACT_SET_USED;
                else if (roll < 45)
                    act = ACT_SET_TIME;
                else if (roll < 65)
                    act = ACT_FIND_FIRST;
                else if (roll < 80)
                    act = ACT_FIND_SECOND;
                else if (roll < 95)
                    act = ACT_READ;
                else
                    act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
                // Mostly valid indexes, some beyond the frame count.
                if (live_slots() > 0 && $urandom_range(0, 9) < 7)
                    idx = FIDX_W'($urandom_range(0, live_slots() - 1));
                else
                    idx = FIDX_W'($urandom_range(0, NUM_SLOTS - 1));
                lower = ($urandom_range(0, 9) < 4) ? '0 : pick_stamp();
                push_cmd(act, idx, $urandom_range(0, 9) < 6, pick_stamp(), lower);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        fault_count += want_reports.size();
        if (fault_count == 0)
            $display("frame_slot_oldest_finder verification clean");
        else
            $display("frame_slot_oldest_finder verification failed");
        $finish;
    end

endmodule
